### design/booke_ee_pkg.sv
package booke_ee_pkg;

   // Request operations.
   localparam logic OP_RAISE = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Exception kinds that have a handler.
   localparam logic [3:0] KIND_CRITICAL = 4'd0;
   localparam logic [3:0] KIND_MCHECK   = 4'd1;
   localparam logic [3:0] KIND_DSTORAGE = 4'd2;
   localparam logic [3:0] KIND_EXTERNAL = 4'd4;
   localparam logic [3:0] KIND_SYSCALL  = 4'd8;
   localparam logic [3:0] KIND_DECR     = 4'd10;
   localparam logic [3:0] KIND_DTLB     = 4'd13;
   localparam logic [3:0] KIND_ITLB     = 4'd14;

   // Configuration register indexes.
   localparam logic [1:0] CSR_VECTOR_PREFIX = 2'd0;
   localparam logic [1:0] CSR_TLB_SELECT    = 2'd1;
   localparam logic [1:0] CSR_PAGE_SIZE     = 2'd2;
   localparam logic [1:0] CSR_PROCESS_ID    = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [31:0] MSR_KEEP_MASK   = 32'h0002_1200;
   localparam logic [31:0] MSR_SYSCALL_CLR = 32'h0002_E930;
   localparam logic [31:0] ESR_DATA_STORE  = 32'h0080_0000;
   localparam logic [31:0] TLBSEL_BIT      = 32'h1000_0000;
   localparam logic [31:0] EPN_MASK        = 32'hFFFF_F000;
   localparam logic [31:0] MAS3_KEEP_MASK  = 32'h0000_0C00;
   localparam logic [15:0] OFFSET_MASK     = 16'hFFF0;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  exception_kind;
      logic        is_write_access;
      logic [31:0] fault_address;
      logic [31:0] current_pc;
      logic [31:0] next_pc;
      logic [31:0] current_msr;
      logic [1:0]  victim_hint;
      logic [15:0] offset_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] handler_pc;
      logic [31:0] saved_pc;
      logic [31:0] new_msr;
      logic [31:0] syndrome;
      logic [31:0] saved_fault_address;
      logic [31:0] assist_word0;
      logic [31:0] assist_word1;
      logic [31:0] assist_word2;
      logic [31:0] assist_word3;
      logic [31:0] assist_word6;
      logic        decrementer_status;
      logic        unimplemented;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] vector_prefix;
      logic        tlb_select_default;
      logic [3:0]  page_size_default;
      logic [7:0]  process_id;
   } cfg_type;

endpackage

### design/booke_ee_vec_table.sv
module booke_ee_vec_table #(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/booke_ee_entry.sv
module booke_ee_entry
   import booke_ee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  logic [15:0]  vec_offset,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic [31:0] save_pc_ff, save_pc_in;
   logic [31:0] save_msr_ff, save_msr_in;
   logic [31:0] syndrome_ff, syndrome_in;
   logic [31:0] fault_addr_ff, fault_addr_in;
   logic        decr_ff, decr_in;
   logic [31:0] aw0_ff, aw0_in;
   logic [31:0] aw1_ff, aw1_in;
   logic [31:0] aw2_ff, aw2_in;
   logic [31:0] aw3_ff, aw3_in;
   logic [31:0] aw6_ff, aw6_in;

   logic [31:0] tlb_aw0, tlb_aw1, tlb_aw2, tlb_aw3, tlb_aw6;
   logic [31:0] new_msr;
   logic        taken;
   logic        unimpl;
   logic        tlb_miss;

   // Assist words as a TLB miss leaves them.
   always_comb begin
      tlb_aw0 = ({3'b000, cfg.tlb_select_default, 28'd0}) | (aw0_ff & ~TLBSEL_BIT);
      if (!cfg.tlb_select_default) begin
         tlb_aw0 = {tlb_aw0[31:20], item.victim_hint, 2'b00, tlb_aw0[15:2],
                    ~item.victim_hint};
      end
      tlb_aw3 = aw3_ff & MAS3_KEEP_MASK;
      tlb_aw2 = (item.fault_address & EPN_MASK) | (aw2_ff & ~EPN_MASK);
      tlb_aw1 = {aw1_ff[31:24], cfg.process_id, aw1_ff[15:12], cfg.page_size_default,
                 aw1_ff[7:0]};
      tlb_aw6 = {aw6_ff[31:24], cfg.process_id, aw6_ff[15:0]};
   end

   always_comb begin
      save_pc_in    = save_pc_ff;
      save_msr_in   = save_msr_ff;
      syndrome_in   = syndrome_ff;
      fault_addr_in = fault_addr_ff;
      decr_in       = decr_ff;
      new_msr       = item.current_msr;
      taken         = 1'b0;
      unimpl        = 1'b0;
      tlb_miss      = 1'b0;
      if (item.opcode == OP_RAISE) begin
         taken = 1'b1;
         unique case (item.exception_kind)
            KIND_CRITICAL, KIND_MCHECK, KIND_DSTORAGE: begin
               save_pc_in    = item.next_pc;
               save_msr_in   = item.current_msr;
               syndrome_in   = ESR_DATA_STORE;
               fault_addr_in = item.fault_address;
               new_msr       = item.current_msr & MSR_KEEP_MASK;
            end
            KIND_EXTERNAL: begin
               save_pc_in  = item.next_pc;
               save_msr_in = item.current_msr;
               new_msr     = item.current_msr & MSR_KEEP_MASK;
            end
            KIND_SYSCALL: begin
               save_pc_in  = item.next_pc;
               save_msr_in = item.current_msr;
               new_msr     = item.current_msr & ~MSR_SYSCALL_CLR;
            end
            KIND_DECR: begin
               save_pc_in  = item.next_pc;
               save_msr_in = item.current_msr;
               new_msr     = item.current_msr & MSR_KEEP_MASK;
               decr_in     = 1'b1;
            end
            KIND_DTLB: begin
               save_pc_in    = item.current_pc;
               save_msr_in   = item.current_msr;
               fault_addr_in = item.fault_address;
               new_msr       = item.current_msr & MSR_KEEP_MASK;
               tlb_miss      = 1'b1;
               syndrome_in   = item.is_write_access ? ESR_DATA_STORE : 32'd0;
            end
            KIND_ITLB: begin
               save_pc_in  = item.current_pc;
               save_msr_in = item.current_msr;
               new_msr     = item.current_msr & MSR_KEEP_MASK;
               tlb_miss    = 1'b1;
            end
            default: begin
               taken  = 1'b0;
               unimpl = 1'b1;
            end
         endcase
      end
      aw0_in = tlb_miss ? tlb_aw0 : aw0_ff;
      aw1_in = tlb_miss ? tlb_aw1 : aw1_ff;
      aw2_in = tlb_miss ? tlb_aw2 : aw2_ff;
      aw3_in = tlb_miss ? tlb_aw3 : aw3_ff;
      aw6_in = tlb_miss ? tlb_aw6 : aw6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_pc_ff    <= '0;
         save_msr_ff   <= '0;
         syndrome_ff   <= '0;
         fault_addr_ff <= '0;
         decr_ff       <= 1'b0;
         aw0_ff        <= '0;
         aw1_ff        <= '0;
         aw2_ff        <= '0;
         aw3_ff        <= '0;
         aw6_ff        <= '0;
      end else if (step_en) begin
         save_pc_ff    <= save_pc_in;
         save_msr_ff   <= save_msr_in;
         syndrome_ff   <= syndrome_in;
         fault_addr_ff <= fault_addr_in;
         decr_ff       <= decr_in;
         aw0_ff        <= aw0_in;
         aw1_ff        <= aw1_in;
         aw2_ff        <= aw2_in;
         aw3_ff        <= aw3_in;
         aw6_ff        <= aw6_in;
      end
   end

   // The result shows the state as this request leaves it.
   always_comb begin
      result.handler_pc          = taken ? {cfg.vector_prefix, vec_offset & OFFSET_MASK}
                                         : 32'd0;
      result.saved_pc            = save_pc_in;
      result.new_msr             = new_msr;
      result.syndrome            = syndrome_in;
      result.saved_fault_address = fault_addr_in;
      result.assist_word0        = aw0_in;
      result.assist_word1        = aw1_in;
      result.assist_word2        = aw2_in;
      result.assist_word3        = aw3_in;
      result.assist_word6        = aw6_in;
      result.decrementer_status  = decr_in;
      result.unimplemented       = unimpl;
   end

   // The saved machine state word is kept although no result shows it.
   logic msr_unused;
   assign msr_unused = ^save_msr_ff;

endmodule

### design/booke_exception_entry_core.sv
// Exception entry unit of an embedded core.
// Requests arrive on the req_ stream: tuser carries the operation (raise an
// exception or write one vector offset entry), tdata the exception kind and
// the context of the faulting instruction. Every request gives exactly one
// result on the rsp_ stream, in request order.
// A request is held in the input register, where the vector offset
// table is read, and then passes through the entry logic into the output
// register, which presents the result on the rsp_ stream.
// One request is taken every cycle unless the receiver stalls; the limit
// is the single read port of the offset table, read as each request is taken.
// When the receiver stalls, the result holds in the output register and one
// more request may wait in the input register; req_tready falls only when
// both are full.
// Reset clears the saved state, assist words and configuration registers.
// The offset table is not cleared: each entry must be written before its
// kind is raised. The user must write configuration through the csr_ port
// only while the block is idle; the block itself does not enforce this.
module booke_exception_entry_core
   import booke_ee_pkg::*;
#(
   parameter int NUM_VECTORS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // exception_kind[3:0], is_write_access[4], fault_address[36:5],
   // current_pc[68:37], next_pc[100:69], current_msr[132:101],
   // victim_hint[134:133], offset_value[150:135], zero pad[151]
   input  logic [151:0]               req_tdata,
   // opcode[0]
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // handler_pc[31:0], saved_pc[63:32], new_msr[95:64], syndrome[127:96],
   // saved_fault_address[159:128], assist_word0[191:160],
   // assist_word1[223:192], assist_word2[255:224], assist_word3[287:256],
   // assist_word6[319:288], decrementer_status[320], zero pad[327:321]
   output logic [327:0]               rsp_tdata,
   // unimplemented[0]
   output logic                       rsp_tuser,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int VEC_AW = $clog2(NUM_VECTORS);

   req_item_type req_item;
   req_item_type s1_item_ff;
   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type entry_result;
   logic         rsp_valid_ff, rsp_valid_in;
   cfg_type      cfg_ff, cfg_in;
   logic [15:0]  vec_offset;
   logic         out_free;
   logic         advance;
   logic         req_fire;

   assign req_item.opcode          = req_tuser;
   assign req_item.exception_kind  = req_tdata[3:0];
   assign req_item.is_write_access = req_tdata[4];
   assign req_item.fault_address   = req_tdata[36:5];
   assign req_item.current_pc      = req_tdata[68:37];
   assign req_item.next_pc         = req_tdata[100:69];
   assign req_item.current_msr     = req_tdata[132:101];
   assign req_item.victim_hint     = req_tdata[134:133];
   assign req_item.offset_value    = req_tdata[150:135];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VECTOR_PREFIX: cfg_in.vector_prefix      = csr_wdata;
            CSR_TLB_SELECT:    cfg_in.tlb_select_default = csr_wdata[0];
            CSR_PAGE_SIZE:     cfg_in.page_size_default  = csr_wdata[3:0];
            CSR_PROCESS_ID:    cfg_in.process_id         = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= entry_result;
      end
   end

   // Offset writes go in at acceptance, so a later request always reads them.
   booke_ee_vec_table #(
      .DEPTH (NUM_VECTORS)
   ) u_vec_table (
      .clock   (clock),
      .wr_en   (req_fire && (req_item.opcode == OP_WRITE)),
      .wr_addr (VEC_AW'(req_item.exception_kind)),
      .wr_data (req_item.offset_value),
      .rd_en   (req_fire),
      .rd_addr (VEC_AW'(req_item.exception_kind)),
      .rd_data (vec_offset)
   );

   booke_ee_entry u_entry (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (s1_item_ff),
      .vec_offset (vec_offset),
      .cfg        (cfg_ff),
      .result     (entry_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.unimplemented;
   assign rsp_tdata  = {7'd0,
                        rsp_item_ff.decrementer_status,
                        rsp_item_ff.assist_word6,
                        rsp_item_ff.assist_word3,
                        rsp_item_ff.assist_word2,
                        rsp_item_ff.assist_word1,
                        rsp_item_ff.assist_word0,
                        rsp_item_ff.saved_fault_address,
                        rsp_item_ff.syndrome,
                        rsp_item_ff.new_msr,
                        rsp_item_ff.saved_pc,
                        rsp_item_ff.handler_pc};

endmodule
